/* rtl/scla_pkg.sv */
// Shared types and constants of the serial command line assembler.
`default_nettype none
package scla_pkg;

	localparam int LINE_DEPTH = 32;
	localparam int LINE_AW    = $clog2(LINE_DEPTH);
	localparam int FILL_W     = 6;
	localparam int PREFIX_W   = 5;

	localparam logic [7:0] SPACE_BYTE = 8'd32;

	typedef enum logic [1:0] {
		KIND_ECHO = 2'd0,
		KIND_LINE = 2'd1,
		KIND_TERM = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		CFG_END_CHAR   = 3'd0,
		CFG_BS_CHAR    = 3'd1,
		CFG_START_CHAR = 3'd2,
		CFG_START_CNT  = 3'd3,
		CFG_ADDR_EN    = 3'd4,
		CFG_ADDR_VAL   = 3'd5,
		CFG_ECHO_EN    = 3'd6,
		CFG_FLOOR      = 3'd7
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BS_SPACE,
		ST_BS_ECHO,
		ST_LINE_OUT,
		ST_TERM
	} state_t;

	typedef struct packed {
		logic               we;
		logic [LINE_AW-1:0] waddr;
		logic [7:0]         wdata;
		logic               re;
		logic [LINE_AW-1:0] raddr;
	} store_req_t;

endpackage
`default_nettype wire

/* rtl/scla_store.sv */
// Line store: single-port-write, registered-read byte memory.
`default_nettype none
module scla_store
	import scla_pkg::*;
(
	input  wire logic       clk,
	input  wire store_req_t req,
	output logic [7:0]      rd_data
);

	logic [7:0] mem [LINE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_data <= mem[req.raddr];
		end
	end

endmodule
`default_nettype wire

/* rtl/serial_command_line_assembler.sv */
// Top level of the serial command line assembler.
// Timing: an echo result is registered and appears the cycle after its transaction; line output
// passes the store read register, then the output register. One byte per cycle when the output
// register is free; input waits while a backspace echo or an end byte's line and terminator go out.
// Reset: asynchronous, clears framing, fill count, registers to defaults; store not cleared.
`default_nettype none
module serial_command_line_assembler
	import scla_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] out_byte
	output logic [1:0]      m_tuser,   // [1:0] out_kind
	output logic            m_tlast,
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	logic [7:0] end_char_q, bs_char_q, start_char_q, addr_val_q, floor_q;
	logic [3:0] start_cnt_q;
	logic       addr_en_q, echo_en_q;

	state_t state_q, state_d;
	logic [FILL_W-1:0]   fill_q, fill_d, len_q, len_d, idx_q, idx_d;
	logic [PREFIX_W-1:0] prefix_q, prefix_d;
	logic [7:0]          hold_q, hold_d;

	logic       m_valid_q, m_last_q;
	logic [7:0] m_byte_q;
	kind_t      m_kind_q;

	logic       ld;
	kind_t      ld_kind;
	logic [7:0] ld_byte;
	logic       ld_last;

	store_req_t req;
	logic [7:0] rd_data;

	logic                slot_free, full;
	logic [FILL_W-1:0]   fill_eff, idx_inc;
	logic [PREFIX_W-1:0] pre_eff, cnt_ext;
	logic                start_act, addr_act, end_hit, bs_hit, store_hit;

	scla_store u_store (
		.clk     (clk),
		.req     (req),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_char_q   <= 8'd10;
			bs_char_q    <= 8'd8;
			start_char_q <= 8'd0;
			start_cnt_q  <= 4'd0;
			addr_en_q    <= 1'b0;
			addr_val_q   <= 8'd0;
			echo_en_q    <= 1'b0;
			floor_q      <= 8'd31;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_END_CHAR:   end_char_q   <= cfg_data;
				CFG_BS_CHAR:    bs_char_q    <= cfg_data;
				CFG_START_CHAR: start_char_q <= cfg_data;
				CFG_START_CNT:  start_cnt_q  <= cfg_data[3:0];
				CFG_ADDR_EN:    addr_en_q    <= cfg_data[0];
				CFG_ADDR_VAL:   addr_val_q   <= cfg_data;
				CFG_ECHO_EN:    echo_en_q    <= cfg_data[0];
				CFG_FLOOR:      floor_q      <= cfg_data;
			endcase
		end
	end

	assign slot_free = !m_valid_q || m_tready;
	assign full      = fill_q >= FILL_W'(LINE_DEPTH);
	assign fill_eff  = full ? '0 : fill_q;
	assign pre_eff   = full ? '0 : prefix_q;
	assign cnt_ext   = PREFIX_W'(start_cnt_q);
	assign idx_inc   = idx_q + FILL_W'(1);

	assign start_act = (start_char_q != 8'd0) && (pre_eff < cnt_ext);
	assign addr_act  = !start_act && addr_en_q && (pre_eff == cnt_ext);
	assign end_hit   = !start_act && !addr_act && (s_tdata == end_char_q);
	assign bs_hit    = !start_act && !addr_act && !end_hit && (s_tdata == bs_char_q)
		&& (fill_eff != '0);
	assign store_hit = !start_act && !addr_act && !end_hit && !bs_hit
		&& (s_tdata > floor_q) && (fill_eff < FILL_W'(LINE_DEPTH));

	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		prefix_d  = prefix_q;
		len_d     = len_q;
		idx_d     = idx_q;
		hold_d    = hold_q;
		s_tready  = 1'b0;
		ld        = 1'b0;
		ld_kind   = KIND_ECHO;
		ld_byte   = 8'd0;
		ld_last   = 1'b0;
		req       = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = slot_free;
				if (s_tvalid && slot_free) begin
					fill_d   = fill_eff;
					prefix_d = pre_eff;
					hold_d   = s_tdata;
					if (echo_en_q) begin
						ld      = 1'b1;
						ld_kind = KIND_ECHO;
						ld_byte = s_tdata;
						ld_last = !(end_hit || bs_hit);
					end
					if (start_act) begin
						prefix_d = (s_tdata == start_char_q) ? pre_eff + PREFIX_W'(1) : '0;
					end else if (addr_act) begin
						prefix_d = (s_tdata == addr_val_q) ? pre_eff + PREFIX_W'(1) : '0;
					end else if (end_hit) begin
						len_d    = fill_eff;
						idx_d    = '0;
						fill_d   = '0;
						prefix_d = '0;
						if (fill_eff != '0) begin
							req.re    = 1'b1;
							req.raddr = '0;
							state_d   = ST_LINE_OUT;
						end else begin
							state_d = ST_TERM;
						end
					end else if (bs_hit) begin
						fill_d = fill_eff - FILL_W'(1);
						if (echo_en_q) begin
							state_d = ST_BS_SPACE;
						end
					end else if (store_hit) begin
						req.we    = 1'b1;
						req.waddr = fill_eff[LINE_AW-1:0];
						req.wdata = s_tdata;
						fill_d    = fill_eff + FILL_W'(1);
					end
				end
			end
			ST_BS_SPACE: begin
				if (slot_free) begin
					ld      = 1'b1;
					ld_kind = KIND_ECHO;
					ld_byte = SPACE_BYTE;
					state_d = ST_BS_ECHO;
				end
			end
			ST_BS_ECHO: begin
				if (slot_free) begin
					ld      = 1'b1;
					ld_kind = KIND_ECHO;
					ld_byte = hold_q;
					ld_last = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_LINE_OUT: begin
				if (slot_free) begin
					ld      = 1'b1;
					ld_kind = KIND_LINE;
					ld_byte = rd_data;
					idx_d   = idx_inc;
					if (idx_inc == len_q) begin
						state_d = ST_TERM;
					end else begin
						req.re    = 1'b1;
						req.raddr = idx_inc[LINE_AW-1:0];
					end
				end
			end
			ST_TERM: begin
				if (slot_free) begin
					ld      = 1'b1;
					ld_kind = KIND_TERM;
					ld_last = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			prefix_q <= '0;
			len_q    <= '0;
			idx_q    <= '0;
		end else begin
			state_q  <= state_d;
			fill_q   <= fill_d;
			prefix_q <= prefix_d;
			len_q    <= len_d;
			idx_q    <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		hold_q <= hold_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (ld) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			m_kind_q <= ld_kind;
			m_byte_q <= ld_byte;
			m_last_q <= ld_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_byte_q;
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(LINE_DEPTH))
		else $error("fill count beyond store depth");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == ST_IDLE)
		else $error("input ready outside idle");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LINE_OUT |-> idx_q < len_q)
		else $error("line read index past line length");

	a_write_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.we |-> s_tvalid && s_tready)
		else $error("store write without input transaction");

	a_load_slot: assert property (@(posedge clk) disable iff (!arst_n)
		ld |-> slot_free)
		else $error("output register overwritten while held");
`endif

endmodule
`default_nettype wire

/* bench/testbench.sv */
// Self-checking testbench of the serial command line assembler: directed table, random frames.
`timescale 1ns / 100ps
module testbench
	import scla_pkg::*;
();

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} line_result_t;

	typedef enum logic {
		ROW_BYTE,
		ROW_CFG
	} row_op_t;

	typedef struct packed {
		row_op_t    op;
		cfg_idx_t   idx;
		logic [7:0] value;
		logic       typed;
		logic [5:0] exp_n;
		kind_t      exp_kind;
		logic [7:0] exp_byte;
	} dir_row_t;

	localparam int DIR_ROWS = 28;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;
	logic       m_tlast;
	logic       cfg_we = 1'b0;
	logic [2:0] cfg_index = 3'd0;
	logic [7:0] cfg_data = 8'h00;

	// predictor registers, starting at the design's reset values and updated by write_reg
	logic [7:0] term_char = 8'd10;
	logic [7:0] erase_char = 8'd8;
	logic [7:0] lead_char = 8'd0;
	logic [3:0] lead_count = 4'd0;
	logic       addr_on = 1'b0;
	logic [7:0] addr_byte = 8'd0;
	logic       echo_on = 1'b0;
	logic [7:0] floor_byte = 8'd31;

	logic [7:0] line_buf [LINE_DEPTH];
	int         fill = 0;
	int         progress = 0;

	line_result_t expected_results [$];
	line_result_t batch [$];
	dir_row_t     rows [DIR_ROWS];
	int           failures = 0;
	int           counted = 0;
	logic         idle_on = 1'b1;

	serial_command_line_assembler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic line_result_t result_of(input kind_t kind, input logic [7:0] data);
		line_result_t r;
		r.kind = kind;
		r.data = data;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic void assemble_byte(input logic [7:0] rx);
		batch.delete();
		if (fill >= LINE_DEPTH) begin
			fill = 0;
			progress = 0;
		end
		if (echo_on)
			batch.push_back(result_of(KIND_ECHO, rx));
		if (lead_char != 8'd0 && progress < lead_count) begin
			progress = (rx == lead_char) ? progress + 1 : 0;
		end else if (addr_on && progress == lead_count) begin
			progress = (rx == addr_byte) ? progress + 1 : 0;
		end else if (rx == term_char) begin
			for (int i = 0; i < fill; i++)
				batch.push_back(result_of(KIND_LINE, line_buf[i]));
			batch.push_back(result_of(KIND_TERM, 8'h00));
			fill = 0;
			progress = 0;
		end else if (rx == erase_char && fill > 0) begin
			fill--;
			if (echo_on) begin
				batch.push_back(result_of(KIND_ECHO, SPACE_BYTE));
				batch.push_back(result_of(KIND_ECHO, rx));
			end
		end else if (rx > floor_byte && fill < LINE_DEPTH) begin
			line_buf[fill] = rx;
			fill++;
		end
		if (batch.size() > 0)
			batch[batch.size() - 1].last = 1'b1;
		foreach (batch[i])
			expected_results.push_back(batch[i]);
	endfunction

	task automatic send_byte(input logic [7:0] b);
		while (idle_on && $urandom_range(99) < 25) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = b;
		do begin
			@(posedge clk);
		end while (!s_tready);
		assemble_byte(b);
		counted++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid = 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [7:0] v);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		case (idx)
			CFG_END_CHAR:   term_char = v;
			CFG_BS_CHAR:    erase_char = v;
			CFG_START_CHAR: lead_char = v;
			CFG_START_CNT:  lead_count = v[3:0];
			CFG_ADDR_EN:    addr_on = v[0];
			CFG_ADDR_VAL:   addr_byte = v;
			CFG_ECHO_EN:    echo_on = v[0];
			CFG_FLOOR:      floor_byte = v;
			default:        ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic random_config(input int phase);
		logic [7:0] v_end;
		logic [7:0] v_bs;
		logic [7:0] v_start;
		logic [7:0] v_cnt;
		logic [7:0] v_aen;
		logic [7:0] v_aval;
		logic [7:0] v_echo;
		logic [7:0] v_floor;
		v_end = $urandom_range(1) ? 8'd10 : 8'($urandom_range(255));
		v_bs = $urandom_range(1) ? 8'd8 : 8'($urandom_range(255));
		v_start = ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom_range(255, 1));
		v_cnt = 8'($urandom_range(4));
		v_aen = 8'($urandom_range(1));
		v_aval = 8'($urandom_range(255));
		v_echo = 8'($urandom_range(1));
		v_floor = $urandom_range(1) ? 8'd31 : 8'($urandom_range(255));
		case (phase)
			1: begin
				v_end = 8'hFF;
				v_floor = 8'h00;
				v_start = 8'hFF;
				v_cnt = 8'd15;
			end
			2: begin
				v_end = 8'h00;
				v_bs = 8'hFF;
				v_floor = 8'hFF;
				v_start = 8'h00;
				v_cnt = 8'd15;
				v_aen = 8'd1;
				v_aval = 8'h00;
			end
			3: begin
				v_start = 8'h00;
				v_cnt = 8'd0;
				v_aen = 8'd1;
				v_aval = 8'hFF;
				v_echo = 8'd1;
			end
			5: begin
				v_end = 8'd10;
				v_bs = 8'd8;
				v_floor = 8'h00;
				v_echo = 8'd1;
			end
			9: begin
				v_end = 8'd10;
				v_bs = 8'd8;
				v_start = 8'd0;
				v_cnt = 8'd0;
				v_aen = 8'd0;
				v_aval = 8'd0;
				v_echo = 8'd0;
				v_floor = 8'd31;
			end
			default: ;
		endcase
		write_reg(CFG_END_CHAR, v_end);
		write_reg(CFG_BS_CHAR, v_bs);
		write_reg(CFG_START_CHAR, v_start);
		write_reg(CFG_START_CNT, v_cnt);
		write_reg(CFG_ADDR_EN, v_aen);
		write_reg(CFG_ADDR_VAL, v_aval);
		write_reg(CFG_ECHO_EN, v_echo);
		write_reg(CFG_FLOOR, v_floor);
	endtask

	task automatic send_frame(input int len);
		if (lead_char != 8'd0)
			repeat (lead_count) send_byte(lead_char);
		if (addr_on)
			send_byte(addr_byte);
		repeat (len) begin
			if ($urandom_range(99) < 12)
				send_byte(erase_char);
			else if (floor_byte == 8'hFF)
				send_byte(8'($urandom_range(255)));
			else
				send_byte(8'($urandom_range(255, floor_byte + 1)));
		end
		send_byte(term_char);
	endtask

	always @(negedge clk)
		m_tready = !(idle_on && $urandom_range(99) < 25);

	always @(posedge clk) begin
		line_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: out_kind %0d out_byte %0h", m_tuser, m_tdata);
				failures++;
			end else begin
				want = expected_results.pop_front();
				if (m_tuser !== want.kind) begin
					$error("out_kind: expected %0d, actual %0d", want.kind, m_tuser);
					failures++;
				end
				if (m_tdata !== want.data) begin
					$error("out_byte: expected %0h, actual %0h", want.data, m_tdata);
					failures++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0d, actual %0d", want.last, m_tlast);
					failures++;
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int pick;
		rows[0]  = '{ROW_BYTE, CFG_END_CHAR,   8'h0A, 1'b1, 6'd1, KIND_TERM, 8'h00};
		rows[1]  = '{ROW_BYTE, CFG_END_CHAR,   8'h00, 1'b1, 6'd0, KIND_ECHO, 8'h00};
		rows[2]  = '{ROW_BYTE, CFG_END_CHAR,   8'hFF, 1'b0, 6'd0, KIND_ECHO, 8'h00};
		rows[3]  = '{ROW_BYTE, CFG_END_CHAR,   8'h41, 1'b0, 6'd0, KIND_ECHO, 8'h00};
		rows[4]  = '{ROW_BYTE, CFG_END_CHAR,   8'h08, 1'b0, 6'd0, KIND_ECHO, 8'h00};
		rows[5]  = '{ROW_BYTE, CFG_END_CHAR,   8'h0A, 1'b1, 6'd2, KIND_TERM, 8'h00};
		rows[6]  = '{ROW_BYTE, CFG_END_CHAR,   8'h08, 1'b1, 6'd0, KIND_ECHO, 8'h00};
		rows[7]  = '{ROW_CFG,  CFG_ECHO_EN,    8'h01, 1'b0, 6'd0, KIND_ECHO, 8'h00};
		rows[8]  = '{ROW_BYTE, CFG_END_CHAR,   8'h41, 1'b1, 6'd1, KIND_ECHO, 8'h41};
		rows[9]  = '{ROW_BYTE, CFG_END_CHAR,   8'h08, 1'b1, 6'd3, KIND_ECHO, 8'h08};
		rows[10] = '{ROW_BYTE, CFG_END_CHAR,   8'h08, 1'b1, 6'd1, KIND_ECHO, 8'h08};
		rows[11] = '{ROW_CFG,  CFG_FLOOR,      8'h00, 1'b0, 6'd0, KIND_ECHO, 8'h00};
		rows[12] = '{ROW_BYTE, CFG_END_CHAR,   8'h08, 1'b0, 6'd0, KIND_ECHO, 8'h00};
		rows[13] = '{ROW_BYTE, CFG_END_CHAR,   8'h0A, 1'b1, 6'd3, KIND_TERM, 8'h00};
		rows[14] = '{ROW_CFG,  CFG_START_CHAR, 8'h55, 1'b0, 6'd0, KIND_ECHO, 8'h00};
		rows[15] = '{ROW_CFG,  CFG_START_CNT,  8'h02, 1'b0, 6'd0, KIND_ECHO, 8'h00};
		rows[16] = '{ROW_CFG,  CFG_ADDR_EN,    8'h01, 1'b0, 6'd0, KIND_ECHO, 8'h00};
		rows[17] = '{ROW_CFG,  CFG_ADDR_VAL,   8'h3A, 1'b0, 6'd0, KIND_ECHO, 8'h00};
		rows[18] = '{ROW_BYTE, CFG_END_CHAR,   8'h55, 1'b0, 6'd0, KIND_ECHO, 8'h00};
		rows[19] = '{ROW_BYTE, CFG_END_CHAR,   8'h41, 1'b0, 6'd0, KIND_ECHO, 8'h00};
		rows[20] = '{ROW_BYTE, CFG_END_CHAR,   8'h55, 1'b0, 6'd0, KIND_ECHO, 8'h00};
		rows[21] = '{ROW_BYTE, CFG_END_CHAR,   8'h55, 1'b0, 6'd0, KIND_ECHO, 8'h00};
		rows[22] = '{ROW_BYTE, CFG_END_CHAR,   8'h3B, 1'b0, 6'd0, KIND_ECHO, 8'h00};
		rows[23] = '{ROW_BYTE, CFG_END_CHAR,   8'h55, 1'b0, 6'd0, KIND_ECHO, 8'h00};
		rows[24] = '{ROW_BYTE, CFG_END_CHAR,   8'h55, 1'b0, 6'd0, KIND_ECHO, 8'h00};
		rows[25] = '{ROW_BYTE, CFG_END_CHAR,   8'h3A, 1'b0, 6'd0, KIND_ECHO, 8'h00};
		rows[26] = '{ROW_BYTE, CFG_END_CHAR,   8'h42, 1'b0, 6'd0, KIND_ECHO, 8'h00};
		rows[27] = '{ROW_BYTE, CFG_END_CHAR,   8'h0A, 1'b1, 6'd3, KIND_TERM, 8'h00};

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			if (rows[r].op == ROW_CFG) begin
				wait_idle();
				write_reg(rows[r].idx, rows[r].value);
			end else begin
				send_byte(rows[r].value);
				if (rows[r].typed) begin
					if (batch.size() != rows[r].exp_n) begin
						$error("result count: expected %0d, actual %0d", rows[r].exp_n,
							batch.size());
						failures++;
					end else if (rows[r].exp_n > 0) begin
						if (batch[batch.size() - 1].kind != rows[r].exp_kind) begin
							$error("out_kind: expected %0d, actual %0d", rows[r].exp_kind,
								batch[batch.size() - 1].kind);
							failures++;
						end
						if (batch[batch.size() - 1].data != rows[r].exp_byte) begin
							$error("out_byte: expected %0h, actual %0h", rows[r].exp_byte,
								batch[batch.size() - 1].data);
							failures++;
						end
					end
				end
			end
		end

		for (int phase = 0; phase < 10; phase++) begin
			wait_idle();
			random_config(phase);
			idle_on = (phase != 4);
			if (phase == 5)
				send_frame(45);
			while (counted < (phase + 1) * 31) begin
				pick = $urandom_range(99);
				if (pick < 4) begin
					wait_idle();
				end else if (pick < 76) begin
					send_frame(($urandom_range(99) < 10) ? $urandom_range(40, 28)
						: $urandom_range(10));
				end else if (pick < 90) begin
					repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
				end else begin
					// cut the framing short and break it
					if (lead_char != 8'd0)
						repeat ($urandom_range(lead_count)) send_byte(lead_char);
					send_byte(8'($urandom_range(255)));
				end
			end
		end

		s_tvalid = 1'b0;
		for (int c = 0; c < 5000 && expected_results.size() != 0; c++)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (expected_results.size() != 0) begin
			$error("results outstanding: expected 0, actual %0d", expected_results.size());
			failures++;
		end
		if (failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* filelist.f */
rtl/scla_pkg.sv
rtl/scla_store.sv
rtl/serial_command_line_assembler.sv
bench/testbench.sv
